>>> rtl/core/recursive_edge_line_filter_defines.svh
// Assertion macros used by the line filter module.
`ifndef RECURSIVE_EDGE_LINE_FILTER_DEFINES_SVH
`define RECURSIVE_EDGE_LINE_FILTER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define REL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define REL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/relf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package relf_pkg;

  localparam int MaxLine = 1024;
  localparam int AddrW   = $clog2(MaxLine);
  localparam int LenW    = AddrW + 1;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegA    = 3'd1;
  localparam logic [2:0] RegB1   = 3'd2;
  localparam logic [2:0] RegB2   = 3'd3;
  localparam logic [2:0] RegA0   = 3'd4;
  localparam logic [2:0] RegA1   = 3'd5;
  localparam logic [2:0] RegA2   = 3'd6;
  localparam logic [2:0] RegA3   = 3'd7;

  localparam logic ReqPush = 1'b0;
  localparam logic ReqRead = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_MUL,    // causal products in flight
    ST_P_SUM,    // causal sum and write
    ST_A_RD,     // anticausal memory read
    ST_A_MUL,
    ST_A_BACK,
    ST_A_DIFF,
    ST_A_GAIN,
    ST_A_WR,
    ST_R_RD,
    ST_R_OUT
  } relf_state_t;

  // Round a Q32.32 product to Q33.16 (16 fraction bits) before saturation.
  function automatic logic signed [48:0] qround(input logic signed [63:0] p);
    logic signed [64:0] m;
    begin
      m = {p[63], p} + 65'sd32768;
      qround = m[64:16];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    begin
      if (v > 52'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -52'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/relf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module relf_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/recursive_edge_line_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Push: busy through the multiply state, then the sum-and-store state; no new push until idle.
// The ending push then walks the stored samples from the last position down to the first,
// each through read, four multiplies, backward sum, difference, gain and write states.
// Read: the result comes from a registered memory read and is strobed on done.
// rst clears control, history and registers; stores stay undefined.
// Results cannot be stalled by the receiver.
`include "recursive_edge_line_filter_defines.svh"
module recursive_edge_line_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [31:0] sample_value,
  input  wire logic        line_end,
  output logic             done,
  output logic [31:0]      filtered_value,
  output logic [9:0]       position,
  output logic             last_of_line,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import relf_pkg::*;

  relf_state_t state, state_next;

  logic mode, mode_line;
  logic signed [31:0] ca, cb1, cb2, ca0, ca1, ca2, ca3;
  logic signed [31:0] h1, h2, prev, x;
  logic last_push;
  logic [LenW-1:0] len, rptr;
  logic [AddrW-1:0] pos;
  logic ready_line;
  logic signed [31:0] g1, g2, s1, s2, nxt, back, diff, cval, cur;
  logic signed [63:0] p0, p1, p2, p3;

  logic we_s, we_c, we_r;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0] wdata_c, wdata_r;
  logic [31:0] rd_s, rd_c, rd_r;

  relf_ram #(.Depth(MaxLine), .Width(32)) u_samp (
    .clk(clk), .we(we_s), .waddr(waddr), .wdata(x), .raddr(raddr), .rdata(rd_s));
  relf_ram #(.Depth(MaxLine), .Width(32)) u_caus (
    .clk(clk), .we(we_c), .waddr(waddr), .wdata(wdata_c), .raddr(raddr),
    .rdata(rd_c));
  relf_ram #(.Depth(MaxLine), .Width(32)) u_res (
    .clk(clk), .we(we_r), .waddr(waddr), .wdata(wdata_r), .raddr(raddr),
    .rdata(rd_r));

  assign cfg_ready = (state == ST_IDLE);
  assign busy = (state != ST_IDLE);

  logic signed [51:0] csum, bsum;
  logic signed [31:0] cres, bres;
  always_comb begin
    csum = 52'(qround(p0)) + 52'(qround(p1)) - 52'(qround(p2)) - 52'(qround(p3));
    cres = sat32(csum);
    bsum = 52'(qround(p0)) + 52'(qround(p1)) - 52'(qround(p2)) - 52'(qround(p3));
    bres = sat32(bsum);
  end

  // Result value for the write stage: gain applies in derivative mode.
  logic signed [31:0] cval_out;
  always_comb begin
    logic signed [51:0] g;
    g = 52'(qround(p0));
    cval_out = mode_line ? diff : sat32(g);
  end

  always_comb begin
    state_next = state;
    we_s = 1'b0;
    we_c = 1'b0;
    we_r = 1'b0;
    waddr = pos;
    raddr = pos;
    wdata_c = cres;
    wdata_r = cval_out;
    case (state)
      ST_IDLE: begin
        raddr = rptr[AddrW-1:0];
        if (start) begin
          if (req_type == ReqPush) state_next = ST_P_MUL;
          else if (ready_line) state_next = ST_R_RD;
        end
      end
      ST_P_MUL: state_next = ST_P_SUM;
      ST_P_SUM: begin
        we_s = 1'b1;
        we_c = 1'b1;
        state_next = last_push ? ST_A_RD : ST_IDLE;
      end
      ST_A_RD: state_next = ST_A_MUL;
      ST_A_MUL: state_next = ST_A_BACK;
      ST_A_BACK: state_next = ST_A_DIFF;
      ST_A_DIFF: state_next = ST_A_GAIN;
      ST_A_GAIN: state_next = ST_A_WR;
      ST_A_WR: begin
        we_r = 1'b1;
        state_next = (pos == '0) ? ST_IDLE : ST_A_RD;
      end
      ST_R_RD: begin
        raddr = rptr[AddrW-1:0];
        state_next = ST_R_OUT;
      end
      ST_R_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode <= 1'b0;
      {ca, cb1, cb2, ca0, ca1, ca2, ca3} <= '0;
      h1 <= '0;
      h2 <= '0;
      prev <= '0;
      len <= '0;
      rptr <= '0;
      ready_line <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegMode: mode <= cfg_data[0];
          RegA:    ca  <= cfg_data;
          RegB1:   cb1 <= cfg_data;
          RegB2:   cb2 <= cfg_data;
          RegA0:   ca0 <= cfg_data;
          RegA1:   ca1 <= cfg_data;
          RegA2:   ca2 <= cfg_data;
          RegA3:   ca3 <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start && req_type == ReqPush) begin
            logic [LenW-1:0] n;
            logic signed [31:0] pv, hh1, hh2;
            n = ready_line ? '0 : len;
            pv = prev; hh1 = h1; hh2 = h2;
            if (n == '0) begin
              hh1 = '0; hh2 = '0;
              pv = mode ? 32'sd0 : sample_value;
            end
            ready_line <= 1'b0;
            rptr <= '0;
            x <= sample_value;
            pos <= n[AddrW-1:0];
            len <= n + 1'b1;
            last_push <= line_end || (n == LenW'(MaxLine - 1));
            mode_line <= mode;
            h1 <= hh1;
            h2 <= hh2;
            // Products registered; derivative uses prev as a unit term.
            p0 <= mode ? ca0 * $signed(sample_value)
                       : $signed({{16{pv[31]}}, pv, 16'h0});
            p1 <= mode ? ca1 * pv : 64'sd0;
            p2 <= cb1 * hh1;
            p3 <= cb2 * hh2;
            prev <= sample_value;
          end
        end
        ST_P_SUM: begin
          h2 <= h1;
          h1 <= cres;
          g1 <= '0; g2 <= '0; s1 <= '0; s2 <= '0;
          nxt <= x;
        end
        ST_A_MUL: begin
          cur <= rd_s;
          cval <= rd_c;
          p0 <= mode_line ? ca2 * s1 : $signed({{16{nxt[31]}}, nxt, 16'h0});
          p1 <= mode_line ? ca3 * s2 : 64'sd0;
          p2 <= cb1 * g1;
          p3 <= cb2 * g2;
        end
        ST_A_BACK: back <= bres;
        ST_A_DIFF: begin
          diff <= mode_line ? sat32(52'(cval) + 52'(back))
                            : sat32(52'(cval) - 52'(back));
          g2 <= g1;
          g1 <= back;
          if (mode_line) begin
            s2 <= s1; s1 <= cur;
          end else nxt <= cur;
        end
        ST_A_GAIN: p0 <= ca * diff;
        ST_A_WR: begin
          pos <= pos - 1'b1;
          if (pos == '0) ready_line <= 1'b1;
        end
        ST_R_OUT: begin
          done <= 1'b1;
          filtered_value <= rd_r;
          position <= 10'(rptr);
          last_of_line <= (rptr + 1'b1 >= len);
          if (rptr + 1'b1 >= len) begin
            ready_line <= 1'b0;
            len <= '0;
            rptr <= '0;
          end else rptr <= rptr + 1'b1;
        end
        default: ;
      endcase
    end
  end

  `REL_ASSERT_IMP(a_done_idle, clk, rst, done, state == ST_IDLE, "result strobe outside idle")
  `REL_ASSERT_NEXT(a_read_done, clk, rst, state == ST_R_OUT, done, "read produced no strobe")
  `REL_ASSERT_IMP(a_len_bound, clk, rst, 1'b1, len <= LenW'(MaxLine), "line length above maximum")
endmodule
`default_nettype wire

>>> verif/recursive_edge_line_filter_checker.sv
`timescale 1ns / 1ps
module recursive_edge_line_filter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        req_type,
  input  logic [31:0] sample_value,
  input  logic        line_end,
  input  logic        done,
  input  logic [31:0] filtered_value,
  input  logic [9:0]  position,
  input  logic        last_of_line,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import relf_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [9:0]  pos;
    logic        last;
  } line_result_t;

  line_result_t result_fifo[$];

  logic        mode;
  longint      k_a, k_b1, k_b2, k_a0, k_a1, k_a2, k_a3;
  longint      samples[MaxLine];
  longint      causal[MaxLine];
  longint      filtered[MaxLine];
  longint      hist1, hist2, prev;
  int          len, rd_ptr;
  bit          ready;

  function automatic longint clip(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product rounded half up.
  function automatic longint qm(input longint c, input longint v);
    longint m;
    m = c * v + 32768;
    if (m >= 0) return m >>> 16;
    return -((-m + 65535) >>> 16);
  endfunction

  task automatic run_backward();
    longint g1, g2, s1, s2, nxt, cur, back;
    g1 = 0; g2 = 0; s1 = 0; s2 = 0;
    nxt = samples[len-1];
    for (int n = len - 1; n >= 0; n--) begin
      cur = samples[n];
      if (mode == 1'b0) begin
        back = clip(nxt - qm(k_b1, g1) - qm(k_b2, g2));
        filtered[n] = clip(qm(k_a, clip(causal[n] - back)));
        nxt = cur;
      end else begin
        back = clip(qm(k_a2, s1) + qm(k_a3, s2) - qm(k_b1, g1) - qm(k_b2, g2));
        filtered[n] = clip(causal[n] + back);
        s2 = s1;
        s1 = cur;
      end
      g2 = g1;
      g1 = back;
    end
  endtask

  task automatic take_request();
    longint x, c;
    line_result_t r;
    if (req_type == ReqPush) begin
      x = longint'($signed(sample_value));
      if (ready) begin
        ready = 0; len = 0; rd_ptr = 0;
      end
      if (len == 0) begin
        hist1 = 0; hist2 = 0;
        prev = (mode == 1'b0) ? x : 0;
      end
      if (mode == 1'b0)
        c = clip(prev - qm(k_b1, hist1) - qm(k_b2, hist2));
      else
        c = clip(qm(k_a0, x) + qm(k_a1, prev) - qm(k_b1, hist1) - qm(k_b2, hist2));
      samples[len] = x;
      causal[len] = c;
      hist2 = hist1;
      hist1 = c;
      prev = x;
      len++;
      if (line_end || len >= MaxLine) begin
        run_backward();
        ready = 1;
        rd_ptr = 0;
      end
    end else if (ready && rd_ptr < len) begin
      r.value = filtered[rd_ptr][31:0];
      r.pos = rd_ptr[9:0];
      r.last = (rd_ptr + 1 >= len);
      result_fifo.push_back(r);
      if (r.last) begin
        ready = 0; len = 0; rd_ptr = 0;
      end else begin
        rd_ptr++;
      end
    end
  endtask

  always @(posedge clk) begin
    line_result_t e;
    if (rst) begin
      mode = 1'b0;
      k_a = 0; k_b1 = 0; k_b2 = 0; k_a0 = 0; k_a1 = 0; k_a2 = 0; k_a3 = 0;
      hist1 = 0; hist2 = 0; prev = 0;
      len = 0; rd_ptr = 0; ready = 0;
      result_fifo.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (done) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result value %h pos %0d", $time, filtered_value,
                   position);
          fail_count++;
        end else begin
          e = result_fifo.pop_front();
          if (filtered_value !== e.value) begin
            $display("%0t: filtered_value expected %h actual %h", $time, e.value,
                     filtered_value);
            fail_count++;
          end
          if (position !== e.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, e.pos, position);
            fail_count++;
          end
          if (last_of_line !== e.last) begin
            $display("%0t: last_of_line expected %b actual %b", $time, e.last,
                     last_of_line);
            fail_count++;
          end
        end
      end
      // A request taken at the same edge as a register write sees the old value.
      if (start && !busy) take_request();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegMode: mode = cfg_data[0];
          RegA:    k_a  = longint'($signed(cfg_data));
          RegB1:   k_b1 = longint'($signed(cfg_data));
          RegB2:   k_b2 = longint'($signed(cfg_data));
          RegA0:   k_a0 = longint'($signed(cfg_data));
          RegA1:   k_a1 = longint'($signed(cfg_data));
          RegA2:   k_a2 = longint'($signed(cfg_data));
          RegA3:   k_a3 = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      pending = result_fifo.size();
    end
  end

endmodule

>>> verif/recursive_edge_line_filter_tb.sv
`timescale 1ns / 1ps
module recursive_edge_line_filter_tb;
  import relf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = ReqPush;
  logic [31:0] sample_value = '0;
  logic        line_end = 1'b0;
  logic        done;
  logic [31:0] filtered_value;
  logic [9:0]  position;
  logic        last_of_line;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = RegMode;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_pct;
  int          sent;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  recursive_edge_line_filter DUT (.*);
  recursive_edge_line_filter_checker u_checker (.*);

  task automatic send_request(input logic kind, input logic [31:0] value, input logic last);
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 6)) @(posedge clk);
    @(posedge clk);
    start <= 1'b1;
    req_type <= kind;
    sample_value <= value;
    line_end <= last;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    start <= 1'b0;
    sent++;
  endtask

  // Registers change only once the block has drained.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    forever begin
      @(negedge clk);
      if (!busy && pending == 0) break;
    end
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      3: return 32'h0;
      default: return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return {8'h0, 8'($urandom_range(0, 255)), 16'h0};
      2: return 32'h7fffffff;
      3: return 32'h80000000;
      default: return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
    endcase
  endfunction

  task automatic set_all_coefs();
    for (int i = RegA; i <= RegA3; i++) write_reg(i[2:0], pick_coef());
  endtask

  task automatic push_line(input int n);
    for (int i = 0; i < n; i++)
      send_request(ReqPush, pick_sample(), (i == n - 1) ? 1'b1 : 1'b0);
  endtask

  task automatic read_n(input int n);
    for (int i = 0; i < n; i++) send_request(ReqRead, $urandom, 1'($urandom_range(1)));
  endtask

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int n;
    sent = 0;
    idle_pct = 24;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read with nothing ready, extremes, both modes.
    send_request(ReqRead, 32'hffffffff, 1'b1);
    write_reg(RegA, 32'h7fffffff);
    write_reg(RegB1, 32'h80000000);
    write_reg(RegB2, 32'h7fffffff);
    send_request(ReqPush, 32'h7fffffff, 1'b0);
    send_request(ReqPush, 32'h80000000, 1'b0);
    send_request(ReqPush, 32'h00000000, 1'b1);
    read_n(4);
    write_reg(RegMode, 32'd1);
    write_reg(RegA0, 32'h80000000);
    write_reg(RegA1, 32'h7fffffff);
    write_reg(RegA2, 32'h0001_0000);
    write_reg(RegA3, 32'hffff_0000);
    send_request(ReqPush, 32'h80000000, 1'b1);
    read_n(1);
    // Unread results are dropped by the next push.
    send_request(ReqPush, 32'h0010_0000, 1'b0);
    send_request(ReqPush, 32'hfff0_0000, 1'b1);
    read_n(1);
    send_request(ReqPush, 32'h0001_0000, 1'b0);
    // Mode switched in the middle of a line.
    write_reg(RegMode, 32'd0);
    send_request(ReqPush, 32'h0003_0000, 1'b0);
    send_request(ReqPush, 32'h7fff_0000, 1'b1);
    read_n(3);

    while (sent < 760) begin
      if (sent > 500) idle_pct = 0;
      else if (sent > 250) idle_pct = 68;
      if ($urandom_range(3) == 0) begin
        write_reg(RegMode, $urandom_range(1));
        set_all_coefs();
      end
      n = $urandom_range(1, 16);
      if ($urandom_range(9) == 0) begin
        push_line(n / 2 + 1);
        write_reg(RegMode, $urandom_range(1));
        push_line(n);
        n = n + n / 2 + 1;
      end else begin
        push_line(n);
      end
      case ($urandom_range(9))
        0: read_n($urandom_range(0, n - 1));
        1: read_n(n + $urandom_range(1, 3));
        default: read_n(n);
      endcase
    end

    // Full length forces the line to end without line_end.
    for (int i = 0; i < MaxLine; i++) send_request(ReqPush, pick_sample(), 1'b0);
    read_n(6);
    push_line(3);
    read_n(3);

    forever begin
      @(negedge clk);
      if (pending == 0 && !busy) break;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
